// ===== rtl/core/pebs_pkg.sv =====
package pebs_pkg;

  localparam int IO_W              = 32;
  localparam int DT_W              = 31;
  localparam int MUL_DIG_W         = 32;
  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int CFG_IDX_W         = 2;

  localparam logic [DT_W-1:0]    TIMESTEP_RST = 31'd1092;
  // wall distance from the origin after reset, before range clamping
  localparam logic signed [63:0] BOUND_RST    = 64'sd65536000;

  typedef enum logic [1:0] {
    ACT_ADD_FORCE = 2'd0,
    ACT_STEP      = 2'd1,
    ACT_SET_POS   = 2'd2,
    ACT_SET_VEL   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMESTEP     = 2'd0,
    CFG_BOUND_LEFT   = 2'd1,
    CFG_BOUND_RIGHT  = 2'd2,
    CFG_BOUND_BOTTOM = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]             action;
    logic signed [IO_W-1:0] value_x;
    logic signed [IO_W-1:0] value_y;
  } in_item_t;

  typedef struct packed {
    logic signed [IO_W-1:0] pos_x_out;
    logic signed [IO_W-1:0] pos_y_out;
    logic signed [IO_W-1:0] vel_x_out;
    logic signed [IO_W-1:0] vel_y_out;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_ADD_FORCE = 4'd1,
    OP_SET_POS   = 4'd2,
    OP_SET_VEL   = 4'd3,
    OP_ACC_VX    = 4'd4,
    OP_ACC_VY    = 4'd5,
    OP_ACC_PX    = 4'd6,
    OP_ACC_PY    = 4'd7,
    OP_WALL_CHK  = 4'd8,
    OP_WALL_FIX  = 4'd9
  } dp_op_t;

  typedef enum logic [1:0] {
    WALL_LEFT   = 2'd0,
    WALL_RIGHT  = 2'd1,
    WALL_BOTTOM = 2'd2
  } wall_t;

  typedef enum logic [1:0] {
    MSEL_FX = 2'd0,
    MSEL_FY = 2'd1,
    MSEL_VX = 2'd2,
    MSEL_VY = 2'd3
  } mul_sel_t;

  typedef struct packed {
    dp_op_t   op;
    wall_t    wall;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     out_load;
    logic     clr_force;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_status_t;

endpackage

// ===== rtl/core/particle_euler_bounce_step_core.sv =====
// channel   | handshake             | payload
// ----------+-----------------------+--------------------------------------
// input     | in_valid / in_ready   | in_data: action, value_x, value_y
// result    | out_valid / out_ready | out_data: pos_x/y_out, vel_x/y_out
// config    | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// add force, set position and set velocity go straight to the output state;
// a step runs the one shared dt multiplier four times, ND = ceil(VALUE_WIDTH/32)
// digits per run, then checks and fixes the left, right and bottom walls.
// rst_n is synchronous: state cleared, walls and dt back to defaults at once.
// the result register holds while out_ready is low; a new item is still taken
// in that time, and its result waits in the output state until the slot frees.
module particle_euler_bounce_step_core #(
  parameter int VALUE_WIDTH   = pebs_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = pebs_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pebs_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pebs_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pebs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pebs_pkg::IO_W-1:0]      cfg_data
);
  import pebs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pebs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_action(in_data.action),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .status   (status)
  );

  pebs_datapath #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_item  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_item (out_data)
  );

endmodule

// ===== rtl/core/pebs_mul_dt.sv =====
module pebs_mul_dt #(
  parameter int VALUE_WIDTH   = pebs_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = pebs_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] operand,
  input  logic [pebs_pkg::DT_W-1:0]     timestep,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] result
);
  import pebs_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int FB    = FRACTION_BITS;
  localparam int ND    = (VW + MUL_DIG_W - 1) / MUL_DIG_W;
  localparam int MAG_W = ND * MUL_DIG_W;
  localparam int ACC_W = MAG_W + DT_W;
  localparam int Q_W   = ACC_W - FB;
  localparam int P_W   = MUL_DIG_W + DT_W;
  localparam int CNT_W = $clog2(ND + 1);

  localparam logic signed [VW-1:0] RES_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] RES_MIN = {1'b1, {(VW-1){1'b0}}};

  logic                 busy_r, busy_nxt;
  logic                 fin_r, fin_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic signed [VW-1:0] res_r, res_nxt;

  logic [VW-1:0]  mag_in;
  logic [P_W-1:0] prod;
  logic [Q_W-1:0] q;
  logic           over;

  assign mag_in = operand[VW-1] ? (~operand + VW'(1)) : operand;
  // top digit first, accumulator shifts up one digit per cycle
  assign prod   = P_W'(mag_r[MAG_W-1 -: MUL_DIG_W]) * P_W'(timestep);
  assign q      = acc_r[ACC_W-1:FB];
  assign over   = |q[Q_W-1:VW-1];

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = fin_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    if (start) begin
      neg_nxt  = operand[VW-1];
      mag_nxt  = MAG_W'(mag_in);
      acc_nxt  = '0;
      cnt_nxt  = CNT_W'(ND);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (acc_r << MUL_DIG_W) + ACC_W'(prod);
      mag_nxt = mag_r << MUL_DIG_W;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      fin_nxt  = 1'b0;
      done_nxt = 1'b1;
      // magnitude truncated, so the sign goes back on after the shift
      if (neg_r) begin
        res_nxt = over ? RES_MIN : VW'(-q[VW-1:0]);
      end else begin
        res_nxt = over ? RES_MAX : q[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (!busy_r && !fin_r))
    else $error("multiply started while busy");

  a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (cnt_r == '0))
    else $error("finish phase with digits left");

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r && !start) |=> done_r)
    else $error("finish phase did not raise done");
`endif

endmodule

// ===== rtl/core/pebs_datapath.sv =====
module pebs_datapath #(
  parameter int VALUE_WIDTH   = pebs_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = pebs_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pebs_pkg::dp_cmd_t              cmd,
  output pebs_pkg::dp_status_t           status,
  input  pebs_pkg::in_item_t             in_item,
  input  logic                           cfg_we,
  input  logic [pebs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pebs_pkg::IO_W-1:0]      cfg_data,
  output pebs_pkg::out_item_t            out_item
);
  import pebs_pkg::*;

  localparam int VW = VALUE_WIDTH;

  typedef logic signed [VW-1:0] val_t;

  localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;
  localparam val_t VMAX      = VW'(VMAX64);
  localparam val_t VMIN      = VW'(VMIN64);
  localparam val_t RST_RIGHT = VW'((BOUND_RST > VMAX64) ? VMAX64 : BOUND_RST);
  localparam val_t RST_LOW   = VW'((-BOUND_RST < VMIN64) ? VMIN64 : -BOUND_RST);

  function automatic val_t sat_add(val_t a, val_t b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      sat_add = s[VW] ? VMIN : VMAX;
    end else begin
      sat_add = s[VW-1:0];
    end
  endfunction

  function automatic val_t sat_sub(val_t a, val_t b);
    logic [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      sat_sub = s[VW] ? VMIN : VMAX;
    end else begin
      sat_sub = s[VW-1:0];
    end
  endfunction

  function automatic val_t sat_neg(val_t a);
    sat_neg = sat_sub('0, a);
  endfunction

  // particle state and wall registers
  val_t fx_r, fx_nxt, fy_r, fy_nxt;
  val_t vx_r, vx_nxt, vy_r, vy_nxt;
  val_t px_r, px_nxt, py_r, py_nxt;
  logic [DT_W-1:0] dt_r, dt_nxt;
  val_t bl_r, bl_nxt, br_r, br_nxt, bb_r, bb_nxt;
  logic hit_r, hit_nxt;
  val_t dist_r, dist_nxt;
  out_item_t out_r;

  val_t mul_a, mul_res;
  val_t wall_p, wall_b;
  logic wall_low;

  // io width to internal width: 0 value_x, 1 value_y, 2 config data
  logic [IO_W-1:0] io_raw [3];
  val_t            io_val [3];
  val_t            st_val [4];
  logic [IO_W-1:0] out_val [4];

  assign io_raw[0] = in_item.value_x;
  assign io_raw[1] = in_item.value_y;
  assign io_raw[2] = cfg_data;

  for (genvar i = 0; i < 3; i++) begin : g_in
    logic signed [IO_W-1:0] raw_s;
    assign raw_s = io_raw[i];
    if (VW >= IO_W) begin : g_ext
      assign io_val[i] = VW'(raw_s);
    end else begin : g_clamp
      localparam logic signed [IO_W-1:0] LIM_HI = IO_W'(VMAX64);
      localparam logic signed [IO_W-1:0] LIM_LO = IO_W'(VMIN64);
      assign io_val[i] = (raw_s > LIM_HI) ? VMAX :
                         (raw_s < LIM_LO) ? VMIN : VW'(raw_s);
    end
  end

  assign st_val[0] = px_r;
  assign st_val[1] = py_r;
  assign st_val[2] = vx_r;
  assign st_val[3] = vy_r;

  for (genvar i = 0; i < 4; i++) begin : g_out
    if (VW > IO_W) begin : g_clamp
      localparam logic signed [63:0] O_HI64 = (64'sd1 <<< (IO_W - 1)) - 64'sd1;
      localparam val_t O_HI = VW'(O_HI64);
      localparam val_t O_LO = VW'(-O_HI64 - 64'sd1);
      assign out_val[i] = (st_val[i] > O_HI) ? IO_W'(O_HI) :
                          (st_val[i] < O_LO) ? IO_W'(O_LO) : IO_W'(st_val[i]);
    end else begin : g_ext
      assign out_val[i] = IO_W'(st_val[i]);
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MSEL_FX: mul_a = fx_r;
      MSEL_FY: mul_a = fy_r;
      MSEL_VX: mul_a = vx_r;
      default: mul_a = vy_r;
    endcase
  end

  always_comb begin
    wall_low = (cmd.wall != WALL_RIGHT);
    case (cmd.wall)
      WALL_LEFT: begin
        wall_p = px_r;
        wall_b = bl_r;
      end
      WALL_RIGHT: begin
        wall_p = px_r;
        wall_b = br_r;
      end
      default: begin
        wall_p = py_r;
        wall_b = bb_r;
      end
    endcase
  end

  pebs_mul_dt #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .operand (mul_a),
    .timestep(dt_r),
    .done    (status.mul_done),
    .result  (mul_res)
  );

  always_comb begin
    fx_nxt   = fx_r;
    fy_nxt   = fy_r;
    vx_nxt   = vx_r;
    vy_nxt   = vy_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    hit_nxt  = hit_r;
    dist_nxt = dist_r;
    case (cmd.op)
      OP_ADD_FORCE: begin
        fx_nxt = sat_add(fx_r, io_val[0]);
        fy_nxt = sat_add(fy_r, io_val[1]);
      end
      OP_SET_POS: begin
        px_nxt = io_val[0];
        py_nxt = io_val[1];
      end
      OP_SET_VEL: begin
        vx_nxt = io_val[0];
        vy_nxt = io_val[1];
      end
      OP_ACC_VX: vx_nxt = sat_add(vx_r, mul_res);
      OP_ACC_VY: vy_nxt = sat_add(vy_r, mul_res);
      OP_ACC_PX: px_nxt = sat_add(px_r, mul_res);
      OP_ACC_PY: py_nxt = sat_add(py_r, mul_res);
      OP_WALL_CHK: begin
        // distance past the wall, mirrored back in the fix cycle
        hit_nxt  = wall_low ? (wall_p < wall_b) : (wall_p > wall_b);
        dist_nxt = wall_low ? sat_sub(wall_b, wall_p) : sat_sub(wall_p, wall_b);
      end
      OP_WALL_FIX: begin
        if (hit_r) begin
          case (cmd.wall)
            WALL_LEFT: begin
              px_nxt = sat_add(bl_r, dist_r);
              vx_nxt = sat_neg(vx_r);
            end
            WALL_RIGHT: begin
              px_nxt = sat_sub(br_r, dist_r);
              vx_nxt = sat_neg(vx_r);
            end
            default: begin
              py_nxt = sat_add(bb_r, dist_r);
              vy_nxt = sat_neg(vy_r);
            end
          endcase
        end
      end
      default: ;
    endcase
    if (cmd.clr_force) begin
      fx_nxt = '0;
      fy_nxt = '0;
    end
  end

  always_comb begin
    dt_nxt = dt_r;
    bl_nxt = bl_r;
    br_nxt = br_r;
    bb_nxt = bb_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TIMESTEP:     dt_nxt = cfg_data[DT_W-1:0];
        CFG_BOUND_LEFT:   bl_nxt = io_val[2];
        CFG_BOUND_RIGHT:  br_nxt = io_val[2];
        CFG_BOUND_BOTTOM: bb_nxt = io_val[2];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= '0;
      fy_r <= '0;
      vx_r <= '0;
      vy_r <= '0;
      px_r <= '0;
      py_r <= '0;
      dt_r <= TIMESTEP_RST;
      bl_r <= RST_LOW;
      br_r <= RST_RIGHT;
      bb_r <= RST_LOW;
    end else begin
      fx_r <= fx_nxt;
      fy_r <= fy_nxt;
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
      dt_r <= dt_nxt;
      bl_r <= bl_nxt;
      br_r <= br_nxt;
      bb_r <= bb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= hit_nxt;
    dist_r <= dist_nxt;
    if (cmd.out_load) begin
      out_r.pos_x_out <= out_val[0];
      out_r.pos_y_out <= out_val[1];
      out_r.vel_x_out <= out_val[2];
      out_r.vel_y_out <= out_val[3];
    end
  end

  assign out_item = out_r;

endmodule

// ===== rtl/core/pebs_ctrl.sv =====
module pebs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pebs_pkg::dp_cmd_t    cmd,
  input  pebs_pkg::dp_status_t status
);
  import pebs_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MUL_FX = 12'b0000_0000_0010,
    S_MUL_FY = 12'b0000_0000_0100,
    S_MUL_VX = 12'b0000_0000_1000,
    S_MUL_VY = 12'b0000_0001_0000,
    S_WL_CHK = 12'b0000_0010_0000,
    S_WL_FIX = 12'b0000_0100_0000,
    S_WR_CHK = 12'b0000_1000_0000,
    S_WR_FIX = 12'b0001_0000_0000,
    S_WB_CHK = 12'b0010_0000_0000,
    S_WB_FIX = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NONE;
    cmd.wall      = WALL_LEFT;
    cmd.mul_start = 1'b0;
    cmd.mul_sel   = MSEL_FX;
    cmd.out_load  = 1'b0;
    cmd.clr_force = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (action_t'(in_action))
            ACT_ADD_FORCE: begin
              cmd.op    = OP_ADD_FORCE;
              state_nxt = S_OUT;
            end
            ACT_SET_POS: begin
              cmd.op    = OP_SET_POS;
              state_nxt = S_OUT;
            end
            ACT_SET_VEL: begin
              cmd.op    = OP_SET_VEL;
              state_nxt = S_OUT;
            end
            default: begin
              cmd.mul_start = 1'b1;
              cmd.mul_sel   = MSEL_FX;
              state_nxt     = S_MUL_FX;
            end
          endcase
        end
      end
      // each multiply result but the last is folded in while the next one starts
      S_MUL_FX: begin
        if (status.mul_done) begin
          cmd.op        = OP_ACC_VX;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_FY;
          state_nxt     = S_MUL_FY;
        end
      end
      S_MUL_FY: begin
        if (status.mul_done) begin
          cmd.op        = OP_ACC_VY;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_VX;
          state_nxt     = S_MUL_VX;
        end
      end
      S_MUL_VX: begin
        if (status.mul_done) begin
          cmd.op        = OP_ACC_PX;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_VY;
          state_nxt     = S_MUL_VY;
        end
      end
      S_MUL_VY: begin
        if (status.mul_done) begin
          cmd.op    = OP_ACC_PY;
          state_nxt = S_WL_CHK;
        end
      end
      S_WL_CHK: begin
        cmd.op    = OP_WALL_CHK;
        cmd.wall  = WALL_LEFT;
        state_nxt = S_WL_FIX;
      end
      S_WL_FIX: begin
        cmd.op    = OP_WALL_FIX;
        cmd.wall  = WALL_LEFT;
        state_nxt = S_WR_CHK;
      end
      S_WR_CHK: begin
        cmd.op    = OP_WALL_CHK;
        cmd.wall  = WALL_RIGHT;
        state_nxt = S_WR_FIX;
      end
      S_WR_FIX: begin
        cmd.op    = OP_WALL_FIX;
        cmd.wall  = WALL_RIGHT;
        state_nxt = S_WB_CHK;
      end
      S_WB_CHK: begin
        cmd.op    = OP_WALL_CHK;
        cmd.wall  = WALL_BOTTOM;
        state_nxt = S_WB_FIX;
      end
      S_WB_FIX: begin
        cmd.op        = OP_WALL_FIX;
        cmd.wall      = WALL_BOTTOM;
        cmd.clr_force = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    status.mul_done |-> (state_r == S_MUL_FX || state_r == S_MUL_FY ||
                         state_r == S_MUL_VX || state_r == S_MUL_VY))
    else $error("multiply done outside a multiply state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while still pending");

  a_short_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action != ACT_STEP) |=> (state_r == S_OUT))
    else $error("non-step item did not go straight to output");

  a_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB_FIX) |=> (state_r == S_OUT && !out_valid_r ||
                               state_r == S_OUT && out_valid_r))
    else $error("step sequence did not end in output state");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pebs_pkg::*;

  localparam longint Q_MAX     = 64'sd2147483647;
  localparam longint Q_MIN     = -64'sd2147483648;
  localparam int     LONG_HOLD = 300;
  localparam int     SETTLE    = 50;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_TOGGLE
  } ready_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IO_W-1:0]      cfg_data  = '0;

  particle_euler_bounce_step_core u_dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // particle and wall state as the block should hold it
  longint unsigned dt_q16     = 64'(TIMESTEP_RST);
  longint          wall_left  = -BOUND_RST;
  longint          wall_right = BOUND_RST;
  longint          floor_y    = -BOUND_RST;
  longint          force_x    = 0;
  longint          force_y    = 0;
  longint          vel_x      = 0;
  longint          vel_y      = 0;
  longint          pos_x      = 0;
  longint          pos_y      = 0;

  in_item_t  pending_items[$];
  out_item_t expected_states[$];

  int mismatch_count = 0;
  int results_checked = 0;
  int bounce_count = 0;
  int settings_count = 0;
  int action_count[4] = '{default: 0};
  int hold_req = 0;

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    return clamp_q(a + b);
  endfunction

  function automatic longint sat_diff(longint a, longint b);
    return clamp_q(a - b);
  endfunction

  // exact product, truncated toward zero, then clamped
  function automatic longint scale_by_dt(longint a);
    longint unsigned mag;
    longint unsigned q;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    q = (mag * dt_q16) >> FRACTION_BITS_DEF;
    return (a < 0) ? clamp_q(-longint'(q)) : clamp_q(longint'(q));
  endfunction

  function automatic out_item_t advance_particle(in_item_t it);
    longint    vx;
    longint    vy;
    out_item_t res;
    vx = longint'($signed(it.value_x));
    vy = longint'($signed(it.value_y));
    case (action_t'(it.action))
      ACT_ADD_FORCE: begin
        force_x = sat_sum(force_x, vx);
        force_y = sat_sum(force_y, vy);
      end
      ACT_STEP: begin
        vel_x = sat_sum(vel_x, scale_by_dt(force_x));
        vel_y = sat_sum(vel_y, scale_by_dt(force_y));
        pos_x = sat_sum(pos_x, scale_by_dt(vel_x));
        pos_y = sat_sum(pos_y, scale_by_dt(vel_y));
        if (pos_x < wall_left) begin
          pos_x = sat_sum(wall_left, sat_diff(wall_left, pos_x));
          vel_x = clamp_q(-vel_x);
          bounce_count++;
        end
        if (pos_x > wall_right) begin
          pos_x = sat_diff(wall_right, sat_diff(pos_x, wall_right));
          vel_x = clamp_q(-vel_x);
          bounce_count++;
        end
        if (pos_y < floor_y) begin
          pos_y = sat_sum(floor_y, sat_diff(floor_y, pos_y));
          vel_y = clamp_q(-vel_y);
          bounce_count++;
        end
        force_x = 0;
        force_y = 0;
      end
      ACT_SET_POS: begin
        pos_x = vx;
        pos_y = vy;
      end
      default: begin
        vel_x = vx;
        vel_y = vy;
      end
    endcase
    res.pos_x_out = pos_x[31:0];
    res.pos_y_out = pos_y[31:0];
    res.vel_x_out = vel_x[31:0];
    res.vel_y_out = vel_y[31:0];
    return res;
  endfunction

  // sender: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: pattern changes at random intervals, long hold on request
  ready_mode_t ready_mode = RDY_ALWAYS;
  int pattern_left = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        ready_mode   <= ready_mode_t'($urandom_range(0, 3));
        pattern_left <= $urandom_range(16, 96);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (ready_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:    out_ready <= ~out_ready;
      endcase
    end
  end

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      if (mismatch_count < 10) begin
        $display("mismatch on result %0d, %s: expected %0d (%h), got %0d (%h)",
                 results_checked, name, $signed(want), want, $signed(got), got);
      end
      mismatch_count++;
    end
  endtask

  out_item_t want_state;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_states.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("result transfer with nothing expected: %h", out_data);
          end
          mismatch_count++;
        end else begin
          want_state = expected_states.pop_front();
          check_field("pos_x_out", out_data.pos_x_out, want_state.pos_x_out);
          check_field("pos_y_out", out_data.pos_y_out, want_state.pos_y_out);
          check_field("vel_x_out", out_data.vel_x_out, want_state.vel_x_out);
          check_field("vel_y_out", out_data.vel_y_out, want_state.vel_y_out);
        end
        results_checked++;
      end
      if (in_valid && in_ready) begin
        expected_states = {expected_states, advance_particle(in_data)};
        action_count[in_data.action]++;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TIMESTEP:     dt_q16 = 64'(value[30:0]);
      CFG_BOUND_LEFT:   wall_left = longint'($signed(value));
      CFG_BOUND_RIGHT:  wall_right = longint'($signed(value));
      default:          floor_y = longint'($signed(value));
    endcase
  endtask

  // only called with the block idle
  task automatic program_walls(logic [31:0] dt, logic [31:0] left, logic [31:0] right,
                               logic [31:0] bottom);
    @(posedge clk);
    write_reg(CFG_TIMESTEP, dt);
    write_reg(CFG_BOUND_LEFT, left);
    write_reg(CFG_BOUND_RIGHT, right);
    write_reg(CFG_BOUND_BOTTOM, bottom);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  task automatic queue_item(action_t act, logic [31:0] x, logic [31:0] y);
    in_item_t it;
    it.action  = act;
    it.value_x = x;
    it.value_y = y;
    pending_items = {pending_items, it};
  endtask

  // mostly moderate magnitudes so the particle moves and bounces, plus corners
  function automatic logic [31:0] pick_value();
    int span;
    int mag;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2: return $urandom();
      default: begin
        span = $urandom_range(4, 26);
        mag = $urandom_range(0, 1 << span);
        return $urandom_range(0, 1) ? mag : -mag;
      end
    endcase
  endfunction

  task automatic queue_random(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) queue_item(ACT_ADD_FORCE, pick_value(), pick_value());
      else if (pick < 70) queue_item(ACT_STEP, pick_value(), pick_value());
      else if (pick < 85) queue_item(ACT_SET_POS, pick_value(), pick_value());
      else queue_item(ACT_SET_VEL, pick_value(), pick_value());
    end
  endtask

  // waits until every queued item is sent and every expected result has come back
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_states.size() != 0);
  endtask

  task automatic run_phase(int count, bit with_hold);
    @(negedge clk);
    if (with_hold) hold_req = hold_req + 1;
    queue_random(count);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // corner items under the reset walls and time step
    @(negedge clk);
    queue_item(ACT_STEP,      32'h0000_0000, 32'h0000_0000);
    queue_item(ACT_SET_POS,   32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(ACT_SET_VEL,   32'h8000_0000, 32'h7FFF_FFFF);
    queue_item(ACT_STEP,      32'h0000_0000, 32'h0000_0000);
    queue_item(ACT_ADD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(ACT_ADD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(ACT_ADD_FORCE, 32'hFFFF_FFFF, 32'h0000_0001);
    queue_item(ACT_STEP,      32'h1234_5678, 32'h8765_4321);
    queue_item(ACT_STEP,      32'h0000_0000, 32'h0000_0000);
    // sitting exactly on the left wall does not bounce
    queue_item(ACT_SET_POS,   32'hFC18_0000, 32'h0000_0000);
    queue_item(ACT_SET_VEL,   32'h0000_0000, 32'h0000_0000);
    queue_item(ACT_STEP,      32'h0000_0000, 32'h0000_0000);
    // nothing stops the particle going up
    queue_item(ACT_SET_POS,   32'h0000_0000, 32'h7FFF_F000);
    queue_item(ACT_SET_VEL,   32'h0000_0000, 32'h7FFF_FFFF);
    queue_item(ACT_STEP,      32'h0000_0000, 32'h0000_0000);
    // sets leave the force sum alone
    queue_item(ACT_ADD_FORCE, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_item(ACT_SET_VEL,   32'hAAAA_AAAA, 32'h5555_5555);
    queue_item(ACT_ADD_FORCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(ACT_SET_POS,   32'h0000_0000, 32'h0000_0000);
    queue_item(ACT_STEP,      32'h0000_0000, 32'h0000_0000);
    // just past the right wall and just under the floor, at rest
    queue_item(ACT_SET_POS,   32'h03E8_0001, 32'hFC17_FFFF);
    queue_item(ACT_SET_VEL,   32'h0000_0000, 32'h0000_0000);
    queue_item(ACT_STEP,      32'h0000_0000, 32'h0000_0000);
    drain();

    run_phase(130, 1'b1);

    // unit time step, tight box: frequent bounces
    program_walls(32'h0001_0000, -(32'd50 << 16), 32'd50 << 16, -(32'd50 << 16));
    run_phase(150, 1'b1);

    // largest step, walls at the extremes of the range
    program_walls(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    run_phase(110, 1'b0);

    // zero step, walls crossed over at the extremes
    program_walls(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    run_phase(90, 1'b0);

    // left wall right of the right wall: both mirrors in one step
    program_walls(32'h0000_4000, 32'd100 << 16, -(32'd100 << 16), 32'h0000_0000);
    run_phase(120, 1'b0);

    program_walls($urandom_range(0, 1 << 18), -int'($urandom_range(1 << 16, 1 << 26)),
                  $urandom_range(1 << 16, 1 << 26), -int'($urandom_range(1 << 16, 1 << 26)));
    run_phase(140, 1'b1);

    program_walls(32'(TIMESTEP_RST), 32'(-BOUND_RST), 32'(BOUND_RST), 32'(-BOUND_RST));
    run_phase(90, 1'b0);

    repeat (SETTLE) @(negedge clk);
    if (expected_states.size() != 0) begin
      $display("%0d results never arrived", expected_states.size());
      mismatch_count += expected_states.size();
    end
    $display("checked %0d results: %0d add-force, %0d step, %0d set-position, %0d set-velocity",
             results_checked, action_count[ACT_ADD_FORCE], action_count[ACT_STEP],
             action_count[ACT_SET_POS], action_count[ACT_SET_VEL]);
    $display("%0d wall settings besides reset, %0d bounces, %0d mismatches",
             settings_count, bounce_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS particle_euler_bounce_step_core");
    end else begin
      $display("FAIL particle_euler_bounce_step_core");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d items queued and %0d results outstanding",
             pending_items.size(), expected_states.size());
    $display("FAIL particle_euler_bounce_step_core");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pebs_pkg.sv
rtl/core/pebs_mul_dt.sv
rtl/core/pebs_datapath.sv
rtl/core/pebs_ctrl.sv
rtl/core/particle_euler_bounce_step_core.sv
dv/tb_top.sv
